@@ design/primality_test_64bit_macros.svh @@
// Assertion macros used by the checker file.
`ifndef PRIMALITY_TEST_64BIT_MACROS_SVH
`define PRIMALITY_TEST_64BIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked during reset too.
`define PT_ASSERT_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ design/pt_pkg.sv @@
package pt_pkg;

  localparam int VALUE_W   = 63;
  localparam int CNT_W     = $clog2(VALUE_W);
  localparam int SCNT_W    = $clog2(VALUE_W + 1);
  localparam int BASE_W    = 6;
  localparam int NUM_BASES = 12;
  localparam int BIDX_W    = $clog2(NUM_BASES);
  localparam int SMALL_LIMIT = 40;

  // Fixed witness bases, indexed from the smallest.
  function automatic logic [BASE_W-1:0] base_of(input logic [BIDX_W-1:0] idx);
    logic [BASE_W-1:0] b;
    case (idx)
      BIDX_W'(0):  b = BASE_W'(2);
      BIDX_W'(1):  b = BASE_W'(3);
      BIDX_W'(2):  b = BASE_W'(5);
      BIDX_W'(3):  b = BASE_W'(7);
      BIDX_W'(4):  b = BASE_W'(11);
      BIDX_W'(5):  b = BASE_W'(13);
      BIDX_W'(6):  b = BASE_W'(17);
      BIDX_W'(7):  b = BASE_W'(19);
      BIDX_W'(8):  b = BASE_W'(23);
      BIDX_W'(9):  b = BASE_W'(29);
      BIDX_W'(10): b = BASE_W'(31);
      BIDX_W'(11): b = BASE_W'(37);
      default:     b = BASE_W'(2);
    endcase
    return b;
  endfunction

  // Modular add with both operands below the modulus.
  function automatic logic [VALUE_W-1:0] add_mod(input logic [VALUE_W-1:0] a,
                                                 input logic [VALUE_W-1:0] b,
                                                 input logic [VALUE_W-1:0] m);
    logic [VALUE_W:0] s;
    logic [VALUE_W:0] t;
    logic [VALUE_W-1:0] r;
    s = {1'b0, a} + {1'b0, b};
    t = s - {1'b0, m};
    if (s >= {1'b0, m}) r = t[VALUE_W-1:0];
    else r = s[VALUE_W-1:0];
    return r;
  endfunction

endpackage

@@ design/primality_test_64bit.sv @@
// Deterministic primality test for values below 2^63.
// Input channel: value with in_valid / in_stall; a word is taken when
// in_valid is high and in_stall low. in_stall stays high while a value is
// being worked on, so one value is processed at a time.
// Output channel: is_prime with out_valid / out_stall; one word per value.
// The result sits in an output register; a held result does not block the
// next value from being accepted, only the final handoff waits for the slot.
// Values up to 40 are decided directly by comparison with the bases. Larger
// values are checked base by base: a residue step, a modular power of the
// odd part of value-1, then a squaring chain whose length depends on z, the
// number of trailing zeros of value-1; a base needs at most about 2*63 + z
// modular multiplications, each run on the shared bit-serial multiplier. A
// value finishes early when an early base proves it composite.
// Reset clears the sequencer and out_valid; no result is pending.
// While out_stall is high, a valid result word (out_valid and is_prime) holds.
module primality_test_64bit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [pt_pkg::VALUE_W-1:0]  value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        is_prime
);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_SPLIT   = 10'b0000000010,
    S_DIV     = 10'b0000000100,
    S_POW_CHK = 10'b0000001000,
    S_POW_M   = 10'b0000010000,
    S_POW_S   = 10'b0000100000,
    S_CHK     = 10'b0001000000,
    S_SQ_CHK  = 10'b0010000000,
    S_SQ      = 10'b0100000000,
    S_DONE    = 10'b1000000000
  } state_t;

  state_t state;

  logic [pt_pkg::VALUE_W-1:0] n;
  logic [pt_pkg::VALUE_W-1:0] d;
  logic [pt_pkg::VALUE_W-1:0] e;
  logic [pt_pkg::VALUE_W-1:0] res;
  logic [pt_pkg::VALUE_W-1:0] sq;
  logic [pt_pkg::SCNT_W-1:0]  s;
  logic [pt_pkg::SCNT_W-1:0]  r;
  logic [pt_pkg::CNT_W-1:0]   cnt;
  logic [pt_pkg::BIDX_W-1:0]  bi;
  logic [pt_pkg::BASE_W-1:0]  rem;
  logic                       verdict;

  logic [pt_pkg::BASE_W-1:0]  base;
  logic [pt_pkg::VALUE_W-1:0] base_full;
  logic [pt_pkg::BASE_W:0]    rem_sh;
  logic [pt_pkg::BASE_W:0]    rem_sub;
  logic [pt_pkg::BASE_W-1:0]  rem_next;
  logic [pt_pkg::VALUE_W-1:0] n_m1;
  logic                       small_hit;
  logic                       last_base;

  logic                       mul_start;
  logic [pt_pkg::VALUE_W-1:0] mul_x;
  logic [pt_pkg::VALUE_W-1:0] mul_y;
  logic                       mul_done;
  logic [pt_pkg::VALUE_W-1:0] mul_prod;

  assign base      = pt_pkg::base_of(bi);
  assign base_full = pt_pkg::VALUE_W'(base);
  assign n_m1      = n - 1'b1;
  assign last_base = (bi == pt_pkg::BIDX_W'(pt_pkg::NUM_BASES - 1));
  assign in_stall  = (state != S_IDLE);

  // Bring in one bit of n for the residue by the current base
  assign rem_sh   = {rem, e[pt_pkg::VALUE_W-1]};
  assign rem_sub  = rem_sh - {1'b0, base};
  assign rem_next = (rem_sh >= {1'b0, base}) ? rem_sub[pt_pkg::BASE_W-1:0]
                                             : rem_sh[pt_pkg::BASE_W-1:0];

  // Small values are prime exactly when they equal a base
  always_comb begin
    small_hit = 1'b0;
    for (int i = 0; i < pt_pkg::NUM_BASES; i++) begin
      if (value == pt_pkg::VALUE_W'(pt_pkg::base_of(pt_pkg::BIDX_W'(i))))
        small_hit = 1'b1;
    end
  end

  // Issue multiplications to the shared unit
  always_comb begin
    mul_start = 1'b0;
    mul_x     = sq;
    mul_y     = sq;
    case (state)
      S_POW_CHK: begin
        if (e != '0) begin
          mul_start = 1'b1;
          if (e[0]) mul_x = res;
        end
      end
      S_POW_M: begin
        mul_start = mul_done;
      end
      S_SQ_CHK: begin
        mul_x = res;
        mul_y = res;
        mul_start = (r < s);
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  pt_mulmod u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .x     (mul_x),
    .y     (mul_y),
    .m     (n),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // Sequencer: small values decided directly; else split n-1, then per base residue, power and squaring chain
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // Drop a taken result word unless a new one replaces it
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            n <= value;
            d <= value - 1'b1;
            s <= '0;
            if (value <= pt_pkg::VALUE_W'(pt_pkg::SMALL_LIMIT)) begin
              verdict <= small_hit;
              state   <= S_DONE;
            end else begin
              state <= S_SPLIT;
            end
          end
        end
        S_SPLIT: begin
          if (!d[0]) begin
            d <= d >> 1;
            s <= s + 1'b1;
          end else begin
            bi    <= '0;
            e     <= n;
            rem   <= '0;
            cnt   <= pt_pkg::CNT_W'(pt_pkg::VALUE_W - 1);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem <= rem_next;
          if (cnt == '0) begin
            if (rem_next == '0) begin
              verdict <= 1'b0;
              state   <= S_DONE;
            end else begin
              e     <= d;
              res   <= pt_pkg::VALUE_W'(1);
              sq    <= base_full;
              state <= S_POW_CHK;
            end
          end else begin
            e   <= e << 1;
            cnt <= cnt - 1'b1;
          end
        end
        S_POW_CHK: begin
          if (e == '0) state <= S_CHK;
          else if (e[0]) state <= S_POW_M;
          else state <= S_POW_S;
        end
        S_POW_M: begin
          if (mul_done) begin
            res   <= mul_prod;
            state <= S_POW_S;
          end
        end
        S_POW_S: begin
          if (mul_done) begin
            sq    <= mul_prod;
            e     <= e >> 1;
            state <= S_POW_CHK;
          end
        end
        S_CHK: begin
          r <= pt_pkg::SCNT_W'(1);
          if (res == pt_pkg::VALUE_W'(1) || res == n_m1) begin
            if (last_base) begin
              verdict <= 1'b1;
              state   <= S_DONE;
            end else begin
              bi    <= bi + 1'b1;
              e     <= n;
              rem   <= '0;
              cnt   <= pt_pkg::CNT_W'(pt_pkg::VALUE_W - 1);
              state <= S_DIV;
            end
          end else begin
            state <= S_SQ_CHK;
          end
        end
        S_SQ_CHK: begin
          if (r < s) begin
            state <= S_SQ;
          end else begin
            verdict <= 1'b0;
            state   <= S_DONE;
          end
        end
        S_SQ: begin
          if (mul_done) begin
            res <= mul_prod;
            r   <= r + 1'b1;
            if (mul_prod == n_m1) begin
              if (last_base) begin
                verdict <= 1'b1;
                state   <= S_DONE;
              end else begin
                bi    <= bi + 1'b1;
                e     <= n;
                rem   <= '0;
                cnt   <= pt_pkg::CNT_W'(pt_pkg::VALUE_W - 1);
                state <= S_DIV;
              end
            end else begin
              state <= S_SQ_CHK;
            end
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            is_prime  <= verdict;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ design/pt_mulmod.sv @@
// Shift-and-add modular multiplier: each multiplier bit takes a doubling step
// and then a conditional add step; product valid on the done pulse.
module pt_mulmod (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pt_pkg::VALUE_W-1:0]  x,
  input  logic [pt_pkg::VALUE_W-1:0]  y,
  input  logic [pt_pkg::VALUE_W-1:0]  m,
  output logic                        done,
  output logic [pt_pkg::VALUE_W-1:0]  prod
);

  logic [pt_pkg::VALUE_W-1:0] acc;
  logic [pt_pkg::VALUE_W-1:0] xr;
  logic [pt_pkg::VALUE_W-1:0] yr;
  logic [pt_pkg::VALUE_W-1:0] mr;
  logic [pt_pkg::CNT_W-1:0]   cnt;
  logic                       phase;
  logic                       busy;
  logic [pt_pkg::VALUE_W-1:0] sum;

  // Share one adder between doubling and adding x
  assign sum  = pt_pkg::add_mod(acc, phase ? xr : acc, mr);
  assign prod = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        acc   <= '0;
        xr    <= x;
        yr    <= y;
        mr    <= m;
        cnt   <= pt_pkg::CNT_W'(pt_pkg::VALUE_W - 1);
        phase <= 1'b0;
      end else if (busy) begin
        if (!phase) begin
          acc   <= sum;
          phase <= 1'b1;
        end else begin
          if (yr[pt_pkg::VALUE_W-1]) acc <= sum;
          yr    <= yr << 1;
          phase <= 1'b0;
          if (cnt == '0) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
      end
    end
  end

endmodule

@@ design/pt_checker.sv @@
`include "primality_test_64bit_macros.svh"

// Port-level checks on the primality tester.
module pt_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic [pt_pkg::VALUE_W-1:0]  value,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        is_prime
);

  // A stalled result word holds
  `PT_ASSERT_NEXT(a_out_hold, clk, !rst && out_valid && out_stall, out_valid && $stable(is_prime))

  // After reset nothing is pending and the input side is open
  `PT_ASSERT_NEXT(a_reset_clear, clk, rst, !out_valid && !in_stall)

  // The block is busy right after taking a word
  `PT_ASSERT_IMP(a_busy_after_take, clk, rst, in_valid && !in_stall, ##1 in_stall)

  // Zero goes straight out as not prime
  `PT_ASSERT_IMP(a_zero_fast, clk, rst,
                 in_valid && !in_stall && value == '0 && !out_valid,
                 ##2 (out_valid && !is_prime))

endmodule

bind primality_test_64bit pt_checker u_pt_checker (.*);
